[sv/tsg_pkg.sv]
// ----------------------------------------------------------------------------
// Tempo sync gate generator package
// Shared widths, register indexes, gate mode codes and small helpers.
// ----------------------------------------------------------------------------
package tsg_pkg;

  // default parameter values
  localparam int unsigned POSITION_WIDTH_DEF = 48;
  localparam int unsigned CV_BITS_DEF        = 16;

  // fixed field widths
  localparam int unsigned CV_LEVEL_W = 16;
  localparam int unsigned RATE_W     = 18;
  localparam int unsigned BPM_W      = 9;
  localparam int unsigned NUM_W      = 6;
  localparam int unsigned DEN_W      = 7;
  localparam int unsigned DIVC_W     = 3;
  localparam int unsigned IDX_W      = 3;

  // period / measure length division widths
  localparam int unsigned RATE240_W  = 26;  // rate * 240
  localparam int unsigned PER_NUM_W  = 32;  // rate * 240 * num
  localparam int unsigned PER_DEN_W  = 16;  // bpm * den, bpm * div
  localparam int unsigned PW_W       = 12;  // pulse width in samples

  // rate / 100 as multiply by reciprocal, exact for 18-bit rates
  localparam int unsigned PW_RECIP   = 335545;
  localparam int unsigned PW_RECIP_W = 19;
  localparam int unsigned PW_SHIFT   = 25;

  typedef enum logic [1:0] {
    GM_OFF     = 2'd0,
    GM_SYNC    = 2'd1,
    GM_MEASURE = 2'd2,
    GM_CHANNEL = 2'd3
  } gate_mode_e;

  localparam logic [1:0] CV_MODE_TEMPO = 2'd2;

  typedef enum logic [IDX_W-1:0] {
    REG_SAMPLE_RATE = 3'd0,
    REG_BASE_TEMPO  = 3'd1,
    REG_GATE_A_MODE = 3'd2,
    REG_GATE_A_DIV  = 3'd3,
    REG_GATE_B_MODE = 3'd4,
    REG_GATE_B_DIV  = 3'd5,
    REG_CV_A_MODE   = 3'd6,
    REG_CV_B_MODE   = 3'd7
  } cfg_reg_e;

  // division code to log2 of pulses per whole note; unknown codes give 4 (16 pulses)
  function automatic logic [2:0] div_shift(input logic [DIVC_W-1:0] code);
    logic [2:0] sh;
    case (code)
      3'd0:    sh = 3'd2;
      3'd1:    sh = 3'd3;
      3'd2:    sh = 3'd4;
      3'd3:    sh = 3'd5;
      3'd4:    sh = 3'd6;
      default: sh = 3'd4;
    endcase
    return sh;
  endfunction

endpackage

[sv/tempo_sync_gate_generator.sv]
// Throughput: one beat per cycle while not held; a CV tempo stage and two gate
// lanes, each with a pipelined length divider and position modulo divider.
// The pipeline holds as a whole only while a finished result is stalled.
// Reset: configuration returns to 48000 Hz, 120 BPM, gates off, division 16,
// CV inputs not in tempo mode; no beats in flight.
// ----------------------------------------------------------------------------
// Tempo sync gate generator
// Computes effective tempo and two sync, measure or channel gate levels.
// ----------------------------------------------------------------------------
module tempo_sync_gate_generator #(
  parameter int unsigned POSITION_WIDTH = tsg_pkg::POSITION_WIDTH_DEF,
  parameter int unsigned CV_BITS        = tsg_pkg::CV_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration writes
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [tsg_pkg::IDX_W-1:0]      cfg_index_i,
  input  logic [tsg_pkg::RATE_W-1:0]     cfg_data_i,
  // input beats
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [POSITION_WIDTH-1:0]      cycle_position_i,
  input  logic                           is_playing_i,
  input  logic [tsg_pkg::NUM_W-1:0]      beats_per_measure_i,
  input  logic [tsg_pkg::DEN_W-1:0]      beat_unit_i,
  input  logic [tsg_pkg::CV_LEVEL_W-1:0] cv_a_level_i,
  input  logic [tsg_pkg::CV_LEVEL_W-1:0] cv_b_level_i,
  input  logic                           gate_a_channel_on_i,
  input  logic                           gate_b_channel_on_i,
  // result beats
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           gate_a_level_o,
  output logic                           gate_b_level_o,
  output logic [tsg_pkg::BPM_W-1:0]      tempo_in_use_o
);
  import tsg_pkg::*;

  localparam int unsigned CVM  = (1 << CV_BITS) - 1;
  localparam int unsigned TNW  = CV_BITS + 10;
  localparam int unsigned SUMW = CV_BITS + 2;
  localparam logic [TNW-1:0] TBASE = TNW'(41 * CVM);
  localparam int unsigned SW0  = POSITION_WIDTH + 1 + NUM_W + DEN_W + 1 + 2;

  // configuration registers
  logic [RATE_W-1:0] rate_q;
  logic [BPM_W-1:0]  base_bpm_q;
  gate_mode_e        ga_mode_q, gb_mode_q;
  logic [DIVC_W-1:0] ga_div_q, gb_div_q;
  logic [1:0]        cva_mode_q, cvb_mode_q;
  logic [RATE240_W-1:0] rate240_q;
  logic [PW_W-1:0]      pw_q;
  logic [RATE_W+PW_RECIP_W-1:0] pw_prod;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q     <= RATE_W'(48000);
      base_bpm_q <= BPM_W'(120);
      ga_mode_q  <= GM_OFF;
      ga_div_q   <= DIVC_W'(2);
      gb_mode_q  <= GM_OFF;
      gb_div_q   <= DIVC_W'(2);
      cva_mode_q <= 2'd0;
      cvb_mode_q <= 2'd0;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_SAMPLE_RATE: rate_q     <= cfg_data_i;
        REG_BASE_TEMPO:  base_bpm_q <= cfg_data_i[BPM_W-1:0];
        REG_GATE_A_MODE: ga_mode_q  <= gate_mode_e'(cfg_data_i[1:0]);
        REG_GATE_A_DIV:  ga_div_q   <= cfg_data_i[DIVC_W-1:0];
        REG_GATE_B_MODE: gb_mode_q  <= gate_mode_e'(cfg_data_i[1:0]);
        REG_GATE_B_DIV:  gb_div_q   <= cfg_data_i[DIVC_W-1:0];
        REG_CV_A_MODE:   cva_mode_q <= cfg_data_i[1:0];
        REG_CV_B_MODE:   cvb_mode_q <= cfg_data_i[1:0];
        default:         ;
      endcase
    end
  end

  // rate-derived constants: rate * 240 and pulse width max(1, rate / 100)
  assign pw_prod = (RATE_W+PW_RECIP_W)'(rate_q) * (RATE_W+PW_RECIP_W)'(PW_RECIP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate240_q <= '0;
      pw_q      <= PW_W'(1);
    end else begin
      rate240_q <= RATE240_W'(rate_q) * RATE240_W'(240);
      pw_q      <= (pw_prod[PW_SHIFT +: PW_W] == '0) ? PW_W'(1)
                                                     : pw_prod[PW_SHIFT +: PW_W];
    end
  end

  // global advance: move while the output register is free or being taken
  logic out_valid_q;
  logic adv;
  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = !adv;

  // input stage: fix time signature, choose CV, form tempo numerator
  logic                      s0_v_q;
  logic [TNW-1:0]            s0_tnum_q;
  logic [SW0-1:0]            s0_side_q;
  logic [CV_BITS-1:0]        cv_sel;
  logic                      use_cv;
  logic [NUM_W-1:0]          num_fix;
  logic [DEN_W-1:0]          den_fix;

  always_comb begin
    use_cv = (cva_mode_q == CV_MODE_TEMPO) || (cvb_mode_q == CV_MODE_TEMPO);
    cv_sel = (cvb_mode_q == CV_MODE_TEMPO) ? cv_b_level_i[CV_BITS-1:0]
                                           : cv_a_level_i[CV_BITS-1:0];
    num_fix = (beats_per_measure_i == '0) ? NUM_W'(4) : beats_per_measure_i;
    den_fix = (beat_unit_i == '0) ? DEN_W'(4) : beat_unit_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q <= 1'b0;
    end else if (adv) begin
      s0_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s0_tnum_q <= TBASE + TNW'(cv_sel) * TNW'(560);
      s0_side_q <= {cycle_position_i, is_playing_i, num_fix, den_fix, use_cv,
                    gate_a_channel_on_i, gate_b_channel_on_i};
    end
  end

  // CV tempo: round half up of 20 + 280 * level / full scale, taken as
  // floor(x / 2) / M; with M = 2^CV_BITS - 1, hi * 2^CV_BITS + lo splits
  // into hi * M + (hi + lo), so the quotient is hi plus a small correction
  logic [TNW-2:0]   t_half;
  logic [BPM_W-1:0] t_hi;
  logic [SUMW-1:0]  t_sum;
  logic [1:0]       t_corr;
  logic             t_v_q;
  logic [BPM_W-1:0] t_quo_q;
  logic [SW0-1:0]   t_side_q;

  always_comb begin
    t_half = s0_tnum_q[TNW-1:1];
    t_hi   = t_half[TNW-2:CV_BITS];
    t_sum  = SUMW'(t_hi) + SUMW'(t_half[CV_BITS-1:0]);
    if (t_sum >= SUMW'(2 * CVM)) begin
      t_corr = 2'd2;
    end else if (t_sum >= SUMW'(CVM)) begin
      t_corr = 2'd1;
    end else begin
      t_corr = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t_v_q <= 1'b0;
    end else if (adv) begin
      t_v_q <= s0_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      t_quo_q  <= t_hi + BPM_W'(t_corr);
      t_side_q <= s0_side_q;
    end
  end

  logic [POSITION_WIDTH-1:0] t_pos;
  logic                      t_play, t_use_cv, t_cha, t_chb;
  logic [NUM_W-1:0]          t_num;
  logic [DEN_W-1:0]          t_den;
  logic [BPM_W-1:0]          t_bpm;

  assign {t_pos, t_play, t_num, t_den, t_use_cv, t_cha, t_chb} = t_side_q;
  assign t_bpm = t_use_cv ? t_quo_q : base_bpm_q;

  // operand stage: measure length numerator and denominator products
  logic                      s1_v_q;
  logic [BPM_W-1:0]          s1_bpm_q;
  logic [PER_NUM_W-1:0]      s1_mnum_q;
  logic [PER_DEN_W-1:0]      s1_mden_q;
  logic [POSITION_WIDTH-1:0] s1_pos_q;
  logic                      s1_play_q, s1_cha_q, s1_chb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (adv) begin
      s1_v_q <= t_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_bpm_q  <= t_bpm;
      s1_mnum_q <= PER_NUM_W'(rate240_q) * PER_NUM_W'(t_num);
      s1_mden_q <= PER_DEN_W'(t_bpm) * PER_DEN_W'(t_den);
      s1_pos_q  <= t_pos;
      s1_play_q <= t_play;
      s1_cha_q  <= t_cha;
      s1_chb_q  <= t_chb;
    end
  end

  // two gate lanes
  logic             la_v, lb_v, la_gate, lb_gate;
  logic [BPM_W-1:0] la_tempo;

  tsg_lane #(.POSITION_WIDTH(POSITION_WIDTH)) u_lane_a (
    .clk_i, .rst_ni,
    .en_i       (adv),
    .valid_i    (s1_v_q),
    .mode_i     (ga_mode_q),
    .div_code_i (ga_div_q),
    .rate240_i  (rate240_q),
    .pulse_w_i  (pw_q),
    .bpm_i      (s1_bpm_q),
    .mnum_i     (s1_mnum_q),
    .mden_i     (s1_mden_q),
    .pos_i      (s1_pos_q),
    .playing_i  (s1_play_q),
    .chan_on_i  (s1_cha_q),
    .valid_o    (la_v),
    .gate_o     (la_gate),
    .tempo_o    (la_tempo)
  );

  tsg_lane #(.POSITION_WIDTH(POSITION_WIDTH)) u_lane_b (
    .clk_i, .rst_ni,
    .en_i       (adv),
    .valid_i    (s1_v_q),
    .mode_i     (gb_mode_q),
    .div_code_i (gb_div_q),
    .rate240_i  (rate240_q),
    .pulse_w_i  (pw_q),
    .bpm_i      (s1_bpm_q),
    .mnum_i     (s1_mnum_q),
    .mden_i     (s1_mden_q),
    .pos_i      (s1_pos_q),
    .playing_i  (s1_play_q),
    .chan_on_i  (s1_chb_q),
    .valid_o    (lb_v),
    .gate_o     (lb_gate),
    .tempo_o    ()
  );

  // merge lanes into the output register
  logic             ga_q, gb_q;
  logic [BPM_W-1:0] tempo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= la_v && lb_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ga_q    <= la_gate;
      gb_q    <= lb_gate;
      tempo_q <= la_tempo;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign gate_a_level_o = ga_q;
  assign gate_b_level_o = gb_q;
  assign tempo_in_use_o = tempo_q;

endmodule

[sv/tsg_div.sv]
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per stage, NW stages; carries a sideband word alongside.
// ----------------------------------------------------------------------------
module tsg_div #(
  parameter int unsigned NW = 32,
  parameter int unsigned DW = 16,
  parameter int unsigned SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [NW-1:0] quo_o,
  output logic [DW-1:0] rem_o,
  output logic [SW-1:0] side_o
);

  logic          vld_q  [0:NW];
  logic [NW-1:0] num_q  [0:NW];
  logic [NW-1:0] quo_q  [0:NW];
  logic [DW-1:0] rem_q  [0:NW];
  logic [DW-1:0] den_q  [0:NW];
  logic [SW-1:0] side_q [0:NW];

  // stage 0 is the input beat itself
  assign vld_q[0]  = valid_i;
  assign num_q[0]  = num_i;
  assign quo_q[0]  = '0;
  assign rem_q[0]  = '0;
  assign den_q[0]  = den_i;
  assign side_q[0] = side_i;

  for (genvar s = 0; s < NW; s++) begin : g_stage
    logic [DW:0] trial;
    logic [DW:0] diff;
    logic        ge;

    // shift in next dividend bit, subtract when it fits
    always_comb begin
      trial = {rem_q[s], num_q[s][NW-1]};
      diff  = trial - {1'b0, den_q[s]};
      ge    = (trial >= {1'b0, den_q[s]});
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[s+1] <= vld_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        num_q[s+1]  <= {num_q[s][NW-2:0], 1'b0};
        quo_q[s+1]  <= {quo_q[s][NW-2:0], ge};
        rem_q[s+1]  <= ge ? diff[DW-1:0] : trial[DW-1:0];
        den_q[s+1]  <= den_q[s];
        side_q[s+1] <= side_q[s];
      end
    end
  end

  assign valid_o = vld_q[NW];
  assign quo_o   = quo_q[NW];
  assign rem_o   = rem_q[NW];
  assign side_o  = side_q[NW];

endmodule

[sv/tsg_lane.sv]
// ----------------------------------------------------------------------------
// Gate lane
// Period or measure length division, position modulo, pulse compare.
// ----------------------------------------------------------------------------
module tsg_lane #(
  parameter int unsigned POSITION_WIDTH = tsg_pkg::POSITION_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           valid_i,
  input  tsg_pkg::gate_mode_e            mode_i,
  input  logic [tsg_pkg::DIVC_W-1:0]     div_code_i,
  input  logic [tsg_pkg::RATE240_W-1:0]  rate240_i,
  input  logic [tsg_pkg::PW_W-1:0]       pulse_w_i,
  input  logic [tsg_pkg::BPM_W-1:0]      bpm_i,
  input  logic [tsg_pkg::PER_NUM_W-1:0]  mnum_i,
  input  logic [tsg_pkg::PER_DEN_W-1:0]  mden_i,
  input  logic [POSITION_WIDTH-1:0]      pos_i,
  input  logic                           playing_i,
  input  logic                           chan_on_i,
  output logic                           valid_o,
  output logic                           gate_o,
  output logic [tsg_pkg::BPM_W-1:0]      tempo_o
);
  import tsg_pkg::*;

  localparam int unsigned S1W = POSITION_WIDTH + 2 + 2 + BPM_W;
  localparam int unsigned S2W = 2 + 2 + BPM_W + 1;

  logic [PER_NUM_W-1:0] dnum;
  logic [PER_DEN_W-1:0] dden;
  logic [S1W-1:0]       side1_in, side1_out;
  logic                 v1;
  logic [PER_NUM_W-1:0] len;
  logic                 len_zero;
  logic [PER_NUM_W-1:0] mod_den;
  logic [S2W-1:0]       side2_out;
  logic [PER_NUM_W-1:0] rem;

  logic [POSITION_WIDTH-1:0] pos1;
  logic                      play1, chan1, play2, chan2, lz2;
  logic [1:0]                mode1, mode2;
  logic [BPM_W-1:0]          bpm1, bpm2;
  logic                      hit;

  // pick sync period or measure length operands
  always_comb begin
    if (mode_i == GM_SYNC) begin
      dnum = PER_NUM_W'(rate240_i);
      dden = PER_DEN_W'({{(PER_DEN_W-BPM_W){1'b0}}, bpm_i} << div_shift(div_code_i));
    end else begin
      dnum = mnum_i;
      dden = mden_i;
    end
  end

  assign side1_in = {pos_i, playing_i, chan_on_i, mode_i, bpm_i};

  tsg_div #(.NW(PER_NUM_W), .DW(PER_DEN_W), .SW(S1W)) u_len_div (
    .clk_i, .rst_ni, .en_i,
    .valid_i (valid_i),
    .num_i   (dnum),
    .den_i   (dden),
    .side_i  (side1_in),
    .valid_o (v1),
    .quo_o   (len),
    .rem_o   (),
    .side_o  (side1_out)
  );

  assign {pos1, play1, chan1, mode1, bpm1} = side1_out;

  // sync period is at least one; zero measure length forces low
  assign len_zero = (len == '0);
  assign mod_den  = (len_zero && (mode1 == GM_SYNC)) ? PER_NUM_W'(1) : len;

  tsg_div #(.NW(POSITION_WIDTH), .DW(PER_NUM_W), .SW(S2W)) u_mod_div (
    .clk_i, .rst_ni, .en_i,
    .valid_i (v1),
    .num_i   (pos1),
    .den_i   (mod_den),
    .side_i  ({play1, chan1, mode1, bpm1, len_zero}),
    .valid_o (valid_o),
    .quo_o   (),
    .rem_o   (rem),
    .side_o  (side2_out)
  );

  assign {play2, chan2, mode2, bpm2, lz2} = side2_out;

  // pulse compare and mode select
  always_comb begin
    hit = play2 && (bpm2 != '0) && (rem < PER_NUM_W'(pulse_w_i));
    case (gate_mode_e'(mode2))
      GM_SYNC:    gate_o = hit;
      GM_MEASURE: gate_o = hit && !lz2;
      GM_CHANNEL: gate_o = chan2;
      default:    gate_o = 1'b0;
    endcase
  end

  assign tempo_o = bpm2;

endmodule

[verif/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Tempo sync gate generator testbench
// Runs a short table of hand-picked positions and register settings, then
// random phases. Each phase reprograms every register while the block is
// idle and sends bursts of positions. Every result beat is compared with the
// table's expected value or with an in-bench gate and tempo predictor.
// ----------------------------------------------------------------------------
module testbench;
  import tsg_pkg::*;

  localparam int unsigned IDLE_LIMIT   = 3000;
  localparam int unsigned PHASES       = 12;
  localparam int unsigned PHASE_BEATS  = 155;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned DRAIN_CYCLES = 130;

  typedef struct packed {
    logic [47:0] pos;
    logic        playing;
    logic [5:0]  num;
    logic [6:0]  den;
    logic [15:0] cva;
    logic [15:0] cvb;
    logic        cha;
    logic        chb;
  } pos_beat_t;

  typedef struct packed {
    logic       ga;
    logic       gb;
    logic [8:0] tempo;
  } gate_res_t;

  typedef struct packed {
    logic [1:0] setup;
    pos_beat_t  beat;
    logic       known;
    gate_res_t  want;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [17:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [47:0] cycle_position_i = '0;
  logic        is_playing_i = 1'b0;
  logic [5:0]  beats_per_measure_i = '0;
  logic [6:0]  beat_unit_i = '0;
  logic [15:0] cv_a_level_i = '0;
  logic [15:0] cv_b_level_i = '0;
  logic        gate_a_channel_on_i = 1'b0;
  logic        gate_b_channel_on_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        gate_a_level_o;
  logic        gate_b_level_o;
  logic [8:0]  tempo_in_use_o;

  // shadow copy of the register file
  logic [17:0] sh_rate = 18'd48000;
  logic [8:0]  sh_bpm = 9'd120;
  gate_mode_e  sh_mode_a = GM_OFF;
  gate_mode_e  sh_mode_b = GM_OFF;
  logic [2:0]  sh_div_a = 3'd2;
  logic [2:0]  sh_div_b = 3'd2;
  logic [1:0]  sh_cva_mode = 2'd0;
  logic [1:0]  sh_cvb_mode = 2'd0;

  gate_res_t   gates_due_q[$];
  int          mismatches = 0;
  int          beats_sent = 0;
  int          beats_seen = 0;
  int          idle_cnt = 0;
  bit          hold_req = 1'b0;
  bit          hold_done = 1'b0;
  logic [47:0] seq_pos = '0;

  tempo_sync_gate_generator u_dut (.*);

  always #6 clk_i = ~clk_i;

  // ---------------------------------------------------------------- predictor
  function automatic longint unsigned cv_to_bpm(logic [15:0] lvl);
    longint unsigned full;
    full = 65535;
    return (40 * full + 560 * longint'(lvl) + full) / (2 * full);
  endfunction

  function automatic longint unsigned pulses_per_note(logic [2:0] code);
    case (code)
      3'd0:    return 4;
      3'd1:    return 8;
      3'd3:    return 32;
      3'd4:    return 64;
      default: return 16;
    endcase
  endfunction

  function automatic logic gate_for(gate_mode_e mode, logic [2:0] divc, pos_beat_t b,
                                    longint unsigned bpm, logic chan);
    longint unsigned width, span, num, den, rate;
    rate  = sh_rate;
    width = (rate / 100 == 0) ? 1 : rate / 100;
    case (mode)
      GM_SYNC: begin
        if (!b.playing || bpm == 0) return 1'b0;
        span = (rate * 240) / (bpm * pulses_per_note(divc));
        if (span == 0) span = 1;
        return (b.pos % span) < width;
      end
      GM_MEASURE: begin
        if (!b.playing || bpm == 0) return 1'b0;
        num  = (b.num == 0) ? 4 : b.num;
        den  = (b.den == 0) ? 4 : b.den;
        span = (rate * 240 * num) / (bpm * den);
        if (span == 0) return 1'b0;
        return (b.pos % span) < width;
      end
      GM_CHANNEL: return chan;
      default:    return 1'b0;
    endcase
  endfunction

  function automatic gate_res_t predict_gates(pos_beat_t b);
    gate_res_t r;
    longint unsigned bpm;
    bpm = sh_bpm;
    if (sh_cva_mode == CV_MODE_TEMPO) bpm = cv_to_bpm(b.cva);
    if (sh_cvb_mode == CV_MODE_TEMPO) bpm = cv_to_bpm(b.cvb);
    r.ga    = gate_for(sh_mode_a, sh_div_a, b, bpm, b.cha);
    r.gb    = gate_for(sh_mode_b, sh_div_b, b, bpm, b.chb);
    r.tempo = bpm[8:0];
    return r;
  endfunction

  // ------------------------------------------------------------ register port
  task automatic write_reg(cfg_reg_e idx, logic [17:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_SAMPLE_RATE: sh_rate = data;
      REG_BASE_TEMPO:  sh_bpm = data[8:0];
      REG_GATE_A_MODE: sh_mode_a = gate_mode_e'(data[1:0]);
      REG_GATE_A_DIV:  sh_div_a = data[2:0];
      REG_GATE_B_MODE: sh_mode_b = gate_mode_e'(data[1:0]);
      REG_GATE_B_DIV:  sh_div_b = data[2:0];
      REG_CV_A_MODE:   sh_cva_mode = data[1:0];
      default:         sh_cvb_mode = data[1:0];
    endcase
  endtask

  task automatic program_regs(logic [17:0] rate, logic [8:0] bpm, gate_mode_e ma,
                              logic [2:0] da, gate_mode_e mb, logic [2:0] db,
                              logic [1:0] ca, logic [1:0] cb);
    write_reg(REG_SAMPLE_RATE, rate);
    write_reg(REG_BASE_TEMPO, 18'(bpm));
    write_reg(REG_GATE_A_MODE, 18'(ma));
    write_reg(REG_GATE_A_DIV, 18'(da));
    write_reg(REG_GATE_B_MODE, 18'(mb));
    write_reg(REG_GATE_B_DIV, 18'(db));
    write_reg(REG_CV_A_MODE, 18'(ca));
    write_reg(REG_CV_B_MODE, 18'(cb));
    cfg_valid_i <= 1'b0;
  endtask

  // wait until every result is back; the block is then idle
  task automatic drain();
    while (gates_due_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // ------------------------------------------------------------ input beats
  // leaves valid high; the caller lowers it when the burst ends
  task automatic send_beat(pos_beat_t b, logic known, gate_res_t want);
    in_valid_i          <= 1'b1;
    cycle_position_i    <= b.pos;
    is_playing_i        <= b.playing;
    beats_per_measure_i <= b.num;
    beat_unit_i         <= b.den;
    cv_a_level_i        <= b.cva;
    cv_b_level_i        <= b.cvb;
    gate_a_channel_on_i <= b.cha;
    gate_b_channel_on_i <= b.chb;
    do @(posedge clk_i); while (in_stall_o);
    gates_due_q.push_back(known ? want : predict_gates(b));
    beats_sent++;
  endtask

  // ------------------------------------------------------------ result check
  always @(posedge clk_i) begin
    gate_res_t w;
    if (out_valid_o && !out_stall_i) begin
      beats_seen++;
      if (gates_due_q.size() == 0) begin
        $error("result beat with nothing expected");
        mismatches++;
      end else begin
        w = gates_due_q.pop_front();
        if (gate_a_level_o !== w.ga) begin
          $error("gate_a_level: expected %0d, got %0d", w.ga, gate_a_level_o);
          mismatches++;
        end
        if (gate_b_level_o !== w.gb) begin
          $error("gate_b_level: expected %0d, got %0d", w.gb, gate_b_level_o);
          mismatches++;
        end
        if (tempo_in_use_o !== w.tempo) begin
          $error("tempo_in_use: expected %0d, got %0d", w.tempo, tempo_in_use_o);
          mismatches++;
        end
      end
    end
  end

  // receiver: randomly chosen stall patterns, plus one long hold
  initial begin
    int pat;
    int cnt;
    pat = 0;
    cnt = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_done = 1'b1;
        out_stall_i <= 1'b0;
      end else begin
        if (cnt == 0) pat = $urandom_range(2);
        cnt = (cnt + 1) % 64;
        case (pat)
          0:       out_stall_i <= 1'b0;
          1:       out_stall_i <= ($urandom_range(3) == 0);
          default: out_stall_i <= ($urandom_range(3) != 0);
        endcase
      end
    end
  end

  // watchdog: cycles with no beat moving on any channel
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o))
        idle_cnt <= 0;
      else
        idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= IDLE_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // directed table: setup 0 reset values, 1 CV tempo with channel and sync,
  // 2 zero sample rate at top tempo, 3 widest rate at zero tempo
  dir_row_t dir_tbl [18] = '{
    '{2'd0, '{48'h0, 1'b1, 6'd0, 7'd0, 16'h0, 16'h0, 1'b1, 1'b1}, 1'b1, '{1'b0, 1'b0, 9'd120}},
    '{2'd0, '{48'hFFFF_FFFF_FFFF, 1'b0, 6'd63, 7'd127, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0},
      1'b1, '{1'b0, 1'b0, 9'd120}},
    '{2'd0, '{48'h5555_5555_5555, 1'b1, 6'd32, 7'd64, 16'h8000, 16'h7FFF, 1'b1, 1'b0},
      1'b1, '{1'b0, 1'b0, 9'd120}},
    '{2'd0, '{48'hAAAA_AAAA_AAAA, 1'b0, 6'd1, 7'd1, 16'h0001, 16'hFFFE, 1'b0, 1'b1},
      1'b1, '{1'b0, 1'b0, 9'd120}},
    '{2'd1, '{48'h0, 1'b1, 6'd4, 7'd4, 16'hFFFF, 16'h0, 1'b1, 1'b0}, 1'b1, '{1'b1, 1'b1, 9'd20}},
    '{2'd1, '{48'h0, 1'b1, 6'd4, 7'd4, 16'h0, 16'hFFFF, 1'b0, 1'b0}, 1'b1, '{1'b0, 1'b1, 9'd300}},
    '{2'd1, '{48'h0, 1'b0, 6'd4, 7'd4, 16'h0, 16'hFFFF, 1'b1, 1'b1}, 1'b1, '{1'b1, 1'b0, 9'd300}},
    '{2'd1, '{48'd1234, 1'b1, 6'd3, 7'd8, 16'h1234, 16'h8000, 1'b0, 1'b1}, 1'b0, '0},
    '{2'd1, '{48'd1500, 1'b1, 6'd7, 7'd16, 16'h4321, 16'h0001, 1'b1, 1'b0}, 1'b0, '0},
    '{2'd1, '{48'hFFFF_FFFF_FFFF, 1'b1, 6'd0, 7'd0, 16'h0, 16'hFFFE, 1'b0, 1'b0}, 1'b0, '0},
    '{2'd2, '{48'h0, 1'b1, 6'd4, 7'd4, 16'h0, 16'h0, 1'b0, 1'b0}, 1'b1, '{1'b0, 1'b1, 9'd511}},
    '{2'd2, '{48'hFFFF_FFFF_FFFF, 1'b1, 6'd63, 7'd127, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1},
      1'b1, '{1'b0, 1'b1, 9'd511}},
    '{2'd2, '{48'd777, 1'b0, 6'd0, 7'd0, 16'h0, 16'h0, 1'b1, 1'b1}, 1'b1, '{1'b0, 1'b0, 9'd511}},
    '{2'd3, '{48'h0, 1'b1, 6'd4, 7'd4, 16'h0, 16'h0, 1'b1, 1'b1}, 1'b1, '{1'b0, 1'b0, 9'd0}},
    '{2'd3, '{48'hFFFF_FFFF_FFFF, 1'b1, 6'd63, 7'd127, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0},
      1'b1, '{1'b0, 1'b0, 9'd0}},
    '{2'd3, '{48'd5, 1'b0, 6'd0, 7'd0, 16'h0, 16'h0, 1'b1, 1'b0}, 1'b1, '{1'b0, 1'b0, 9'd0}},
    '{2'd3, '{48'd12, 1'b1, 6'd2, 7'd2, 16'h1, 16'h1, 1'b0, 1'b1}, 1'b1, '{1'b0, 1'b0, 9'd0}},
    '{2'd3, '{48'd99, 1'b1, 6'd33, 7'd65, 16'h2, 16'h3, 1'b1, 1'b1}, 1'b1, '{1'b0, 1'b0, 9'd0}}
  };

  // ------------------------------------------------------------ main sequence
  initial begin
    int cur_setup;
    int n;
    int burst;
    int gap;
    int sel;
    logic [17:0] rate;
    logic [8:0]  bpm;
    pos_beat_t   b;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    cur_setup = 0;
    foreach (dir_tbl[i]) begin
      if (dir_tbl[i].setup != cur_setup) begin
        in_valid_i <= 1'b0;
        drain();
        cur_setup = dir_tbl[i].setup;
        case (cur_setup)
          1: program_regs(18'd48000, 9'd0, GM_CHANNEL, 3'd0, GM_SYNC, 3'd4, 2'd2, 2'd2);
          2: program_regs(18'd0, 9'd511, GM_MEASURE, 3'd7, GM_SYNC, 3'd5, 2'd1, 2'd3);
          default: program_regs(18'h3FFFF, 9'd0, GM_SYNC, 3'd6, GM_MEASURE, 3'd1,
                                2'd0, 2'd0);
        endcase
      end
      send_beat(dir_tbl[i].beat, dir_tbl[i].known, dir_tbl[i].want);
    end
    in_valid_i <= 1'b0;

    // random phases
    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      case ($urandom_range(7))
        0: rate = 18'd0;
        1: rate = 18'd1;
        2: rate = 18'h3FFFF;
        3: rate = 18'd192000;
        4: rate = 18'd48000;
        default: rate = 18'($urandom_range(18'h3FFFF));
      endcase
      case ($urandom_range(5))
        0: bpm = 9'd0;
        1: bpm = 9'd511;
        2: bpm = 9'd1;
        default: bpm = 9'($urandom_range(511));
      endcase
      program_regs(rate, bpm, gate_mode_e'($urandom_range(3)), 3'($urandom_range(7)),
                   gate_mode_e'($urandom_range(3)), 3'($urandom_range(7)),
                   ($urandom_range(1) == 0) ? CV_MODE_TEMPO : 2'($urandom_range(3)),
                   ($urandom_range(2) == 0) ? CV_MODE_TEMPO : 2'($urandom_range(3)));
      if (ph == 3) hold_req = 1'b1;
      seq_pos = 48'($urandom_range(100000));
      n = 0;
      while (n < PHASE_BEATS) begin
        burst = $urandom_range(1, 24);
        for (int k = 0; k < burst && n < PHASE_BEATS; k++) begin
          sel = $urandom_range(9);
          if (sel < 4) begin
            b.pos = seq_pos;
            seq_pos = seq_pos + 48'd1 + 48'($urandom_range(40));
          end else if (sel < 7) begin
            b.pos = {16'($urandom), 32'($urandom)};
          end else begin
            b.pos = 48'($urandom_range(1 << 20));
          end
          b.playing = ($urandom_range(7) != 0);
          b.num     = 6'($urandom_range(63));
          b.den     = ($urandom_range(3) == 0) ? 7'($urandom_range(127))
                                               : 7'(1 << $urandom_range(6));
          b.cva     = 16'($urandom);
          b.cvb     = 16'($urandom);
          b.cha     = 1'($urandom);
          b.chb     = 1'($urandom);
          send_beat(b, 1'b0, '0);
          n++;
        end
        gap = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 8);
        if (gap != 0) begin
          in_valid_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      in_valid_i <= 1'b0;
    end

    while (gates_due_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d position beats over %0d random register phases plus a directed table;",
             beats_sent, PHASES);
    $display("checked %0d result beats, %0d field mismatches.", beats_seen, mismatches);
    if (mismatches == 0 && gates_due_q.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
